@@ rtl/udprx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udprx_pkg
// shared constants and types for the udp receive checker and port demux
// ----------------------------------------------------------------------------
package udprx_pkg;

    // number of port table slots
    localparam int PORT_SLOTS = 8;

    // operation codes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_BIND   = 2'd1;
    localparam logic [1:0] OP_UNBIND = 2'd2;

    // status codes
    localparam logic [3:0] ST_DELIVERED  = 4'd0;
    localparam logic [3:0] ST_TOO_SHORT  = 4'd1;
    localparam logic [3:0] ST_BAD_LENGTH = 4'd2;
    localparam logic [3:0] ST_BAD_CSUM   = 4'd3;
    localparam logic [3:0] ST_NO_HANDLER = 4'd4;
    localparam logic [3:0] ST_BOUND      = 4'd5;
    localparam logic [3:0] ST_TABLE_FULL = 4'd6;
    localparam logic [3:0] ST_UNBOUND    = 4'd7;
    localparam logic [3:0] ST_NOT_FOUND  = 4'd8;

    // header and checksum constants
    localparam logic [16:0] POS_MAX       = 17'h1FFFF;
    localparam logic [16:0] HDR_BYTES     = 17'd8;
    localparam logic [15:0] HDR_LEN_MIN   = 16'd8;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

    typedef logic [PORT_SLOTS-1:0] slot_vec_t;

    // table command, already qualified by the processing strobe
    typedef struct packed {
        logic        bind_req;
        logic        unbind_req;
        logic [15:0] port;
        logic [7:0]  handler;
    } tbl_cmd_t;

    // table response
    typedef struct packed {
        logic [3:0] status;
        logic       hit;
        logic [7:0] handler;
    } tbl_rsp_t;

endpackage
`default_nettype wire

@@ rtl/udprx_port_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udprx_port_table
// port to handler table in flops, first-match bind, unbind and lookup
// ----------------------------------------------------------------------------
module udprx_port_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire udprx_pkg::tbl_cmd_t cmd,
    input  wire logic [15:0]         lookup_port,
    output udprx_pkg::tbl_rsp_t      rsp
);
    import udprx_pkg::*;

    slot_vec_t   slot_valid_reg;
    logic [15:0] slot_port_reg    [PORT_SLOTS];
    logic [7:0]  slot_handler_reg [PORT_SLOTS];

    slot_vec_t   cmd_match;
    slot_vec_t   look_match;
    slot_vec_t   cmd_first;
    slot_vec_t   look_first;
    slot_vec_t   free_first;
    logic [7:0]  look_handler;

    always_comb
    begin
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            cmd_match[i]  = slot_valid_reg[i] && (slot_port_reg[i] == cmd.port);
            look_match[i] = slot_valid_reg[i] && (slot_port_reg[i] == lookup_port);
        end
    end

    // isolate lowest set bit: lowest slot wins
    assign cmd_first  = cmd_match & (~cmd_match + slot_vec_t'(1));
    assign look_first = look_match & (~look_match + slot_vec_t'(1));
    assign free_first = ~slot_valid_reg & (slot_valid_reg + slot_vec_t'(1));

    always_comb
    begin
        look_handler = '0;
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            if (look_first[i])
            begin
                look_handler = look_handler | slot_handler_reg[i];
            end
        end
    end

    always_comb
    begin
        rsp.hit     = |look_match;
        rsp.handler = look_handler;
        if (cmd.unbind_req)
        begin
            rsp.status = (|cmd_match) ? ST_UNBOUND : ST_NOT_FOUND;
        end
        else
        begin
            rsp.status = ((|cmd_match) || !(&slot_valid_reg)) ? ST_BOUND : ST_TABLE_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < PORT_SLOTS; i++)
            begin
                if (cmd.bind_req && !(|cmd_match) && free_first[i])
                begin
                    slot_valid_reg[i] <= 1'b1;
                end
                else if (cmd.unbind_req && cmd_first[i])
                begin
                    slot_valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            if (cmd.bind_req)
            begin
                if (cmd_first[i])
                begin
                    slot_handler_reg[i] <= cmd.handler;
                end
                else if (!(|cmd_match) && free_first[i])
                begin
                    slot_port_reg[i]    <= cmd.port;
                    slot_handler_reg[i] <= cmd.handler;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // a successful bind leaves at least one slot in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bind_req && rsp.status == ST_BOUND) |=> (|slot_valid_reg))
        else $error("bind reported bound but table is empty");

    // full is only reported when every slot is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bind_req && rsp.status == ST_TABLE_FULL) |-> (&slot_valid_reg))
        else $error("table full reported with a free slot");

    // a successful unbind frees exactly one slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.unbind_req && rsp.status == ST_UNBOUND) |=>
        ($countones(slot_valid_reg) + 1 == $past($countones(slot_valid_reg))))
        else $error("unbind did not free exactly one slot");

    // a lookup hit points at a single slot
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.hit |-> $onehot(look_first))
        else $error("lookup first-match vector not one-hot");
`endif

endmodule
`default_nettype wire

@@ rtl/udp_receive_check_and_demux.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udp_receive_check_and_demux
// udp header parse, checksum check and port demux; while results are taken, one byte per cycle
// ----------------------------------------------------------------------------
//
// channel   handshake                     payload
// -------   ---------------------------   -------------------------------------
// item      item_valid / item_ready       operation, data_byte, last_byte,
//                                         source_ip, destination_ip, port,
//                                         handler_id
// result    result_valid / result_ready   status, matched_handler, source_port,
//                                         destination_port, sender_ip,
//                                         payload_length
//
// one transaction per cycle sustained while results are taken; two register stages
// (input register, result register), so a result shows in the cycle after its item is processed
// the whole last-byte check (pseudo-header sum, fold, compare, port match)
// sits between the input register and the result register
// asynchronous reset clears the port table valid bits and datagram state at
// once; no clearing pass, items are taken right after reset
// a stalled result holds the result register; the input register still takes
// one more transaction while the result waits, if the input register was empty
//
module udp_receive_check_and_demux (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [31:0] source_ip,
    input  wire logic [31:0] destination_ip,
    input  wire logic [15:0] port,
    input  wire logic [7:0]  handler_id,
    // result channel
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [3:0]       status,
    output logic [7:0]       matched_handler,
    output logic [15:0]      source_port,
    output logic [15:0]      destination_port,
    output logic [31:0]      sender_ip,
    output logic [15:0]      payload_length
);
    import udprx_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] sip_reg;
    logic [31:0] dip_reg;
    logic [15:0] port_reg;
    logic [7:0]  handler_reg;

    // datagram state
    logic [16:0] pos_reg;
    logic [15:0] sum_reg;
    logic [7:0]  hold_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;
    logic [15:0] len_reg;
    logic [15:0] csum_reg;

    logic [16:0] pos_next;
    logic [15:0] sum_next;
    logic [7:0]  hold_next;
    logic [15:0] sport_next;
    logic [15:0] dport_next;
    logic [15:0] len_next;
    logic [15:0] csum_next;

    // result register
    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [7:0]  matched_reg;
    logic [15:0] sport_out_reg;
    logic [15:0] dport_out_reg;
    logic [31:0] sip_out_reg;
    logic [15:0] plen_reg;

    logic [3:0]  status_next;
    logic [7:0]  matched_next;
    logic [15:0] sport_out_next;
    logic [15:0] dport_out_next;
    logic [31:0] sip_out_next;
    logic [15:0] plen_next;

    // flow control
    logic        out_free;
    logic        proc_fire;
    logic        is_byte;
    logic        res_produce;

    // byte datapath
    logic        pos_lt8;
    logic        csum_byte;
    logic        counted;
    logic [7:0]  byte_val;
    logic [15:0] word_add;
    logic [7:0]  hold_after;
    logic [16:0] sum_acc;
    logic [17:0] total_bytes;
    logic        too_short;
    logic        bad_len;
    logic [15:0] pad_word;
    logic [19:0] csum_total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] calc_inv;
    logic [15:0] calc_csum;
    logic        bad_sum;

    tbl_cmd_t    tbl_cmd;
    tbl_rsp_t    tbl_rsp;

    // ------------------------------------------------------------------------
    // handshake: the processing stage moves whenever the result slot is free
    // ------------------------------------------------------------------------
    assign out_free    = !out_valid_reg || result_ready;
    assign proc_fire   = in_valid_reg && out_free;
    assign item_ready  = !in_valid_reg || out_free;
    assign is_byte     = (op_reg == OP_BYTE);
    assign res_produce = proc_fire &&
                         ((op_reg == OP_BIND) || (op_reg == OP_UNBIND) || (is_byte && last_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg      <= operation;
            byte_reg    <= data_byte;
            last_reg    <= last_byte;
            sip_reg     <= source_ip;
            dip_reg     <= destination_ip;
            port_reg    <= port;
            handler_reg <= handler_id;
        end
    end

    // ------------------------------------------------------------------------
    // header capture and running one's-complement sum
    // ------------------------------------------------------------------------
    assign pos_lt8   = (pos_reg < HDR_BYTES);
    // checksum field bytes count as zero in the sum
    assign csum_byte = pos_lt8 && (pos_reg[2:1] == 2'd3);
    assign byte_val  = csum_byte ? 8'h00 : byte_reg;
    // header always counts; past it only bytes inside the udp length
    assign counted   = pos_lt8 || (pos_reg < {1'b0, len_reg});

    always_comb
    begin
        sport_next = sport_reg;
        dport_next = dport_reg;
        len_next   = len_reg;
        csum_next  = csum_reg;
        if (pos_lt8)
        begin
            case (pos_reg[2:1])
                2'd0:    sport_next = {sport_reg[7:0], byte_reg};
                2'd1:    dport_next = {dport_reg[7:0], byte_reg};
                2'd2:    len_next   = {len_reg[7:0], byte_reg};
                default: csum_next  = {csum_reg[7:0], byte_reg};
            endcase
        end
    end

    // even position holds the high byte, odd position adds the word
    assign word_add   = (counted && pos_reg[0]) ? {hold_reg, byte_val} : 16'h0000;
    assign hold_after = (counted && !pos_reg[0]) ? byte_val : hold_reg;
    assign hold_next  = hold_after;

    // end-around carry
    assign sum_acc  = {1'b0, sum_reg} + {1'b0, word_add};
    assign sum_next = sum_acc[15:0] + {15'd0, sum_acc[16]};

    // saturating byte counter
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 17'd1;

    // ------------------------------------------------------------------------
    // last-byte checks
    // ------------------------------------------------------------------------
    assign total_bytes = {1'b0, pos_reg} + 18'd1;
    assign too_short   = (total_bytes < {1'b0, HDR_BYTES});
    assign bad_len     = (len_next < HDR_LEN_MIN) || ({2'b00, len_next} > total_bytes);

    // odd length: last counted byte padded with a zero low byte
    assign pad_word = len_next[0] ? {hold_after, 8'h00} : 16'h0000;

    // one wide add of accumulator, pending word, pad and pseudo-header, then
    // fold twice; same result as adding the words one at a time since the
    // protocol word keeps the total nonzero
    assign csum_total = {4'd0, sum_reg} + {4'd0, word_add} + {4'd0, pad_word}
                      + {4'd0, sip_reg[31:16]} + {4'd0, sip_reg[15:0]}
                      + {4'd0, dip_reg[31:16]} + {4'd0, dip_reg[15:0]}
                      + {12'd0, PROTO_UDP} + {4'd0, len_next};
    assign fold1      = {1'b0, csum_total[15:0]} + {13'd0, csum_total[19:16]};
    assign fold2      = fold1[15:0] + {15'd0, fold1[16]};
    assign calc_inv   = ~fold2;
    // a computed zero goes on the wire as all ones
    assign calc_csum  = (calc_inv == 16'h0000) ? CSUM_ALL_ONES : calc_inv;
    // received zero means no checksum
    assign bad_sum    = (csum_next != 16'h0000) && (calc_csum != csum_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            len_reg   <= '0;
            csum_reg  <= '0;
        end
        else if (proc_fire && is_byte)
        begin
            if (last_reg)
            begin
                // datagram judged, start over
                pos_reg   <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
                len_reg   <= '0;
                csum_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
                len_reg   <= len_next;
                csum_reg  <= csum_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // port table
    // ------------------------------------------------------------------------
    assign tbl_cmd.bind_req   = proc_fire && (op_reg == OP_BIND);
    assign tbl_cmd.unbind_req = proc_fire && (op_reg == OP_UNBIND);
    assign tbl_cmd.port       = port_reg;
    assign tbl_cmd.handler    = handler_reg;

    udprx_port_table u_port_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (tbl_cmd),
        .lookup_port (dport_next),
        .rsp         (tbl_rsp)
    );

    // ------------------------------------------------------------------------
    // result selection
    // ------------------------------------------------------------------------
    always_comb
    begin
        status_next    = ST_NO_HANDLER;
        matched_next   = '0;
        sport_out_next = '0;
        dport_out_next = '0;
        sip_out_next   = '0;
        plen_next      = '0;
        case (op_reg)
            OP_BIND, OP_UNBIND:
            begin
                status_next = tbl_rsp.status;
            end
            OP_BYTE:
            begin
                if (too_short)
                begin
                    status_next = ST_TOO_SHORT;
                end
                else
                begin
                    sport_out_next = sport_next;
                    dport_out_next = dport_next;
                    sip_out_next   = sip_reg;
                    if (bad_len)
                    begin
                        status_next = ST_BAD_LENGTH;
                    end
                    else
                    begin
                        plen_next = len_next - HDR_LEN_MIN;
                        if (bad_sum)
                        begin
                            status_next = ST_BAD_CSUM;
                        end
                        else if (tbl_rsp.hit)
                        begin
                            status_next  = ST_DELIVERED;
                            matched_next = tbl_rsp.handler;
                        end
                        else
                        begin
                            status_next = ST_NO_HANDLER;
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_NO_HANDLER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_produce)
        begin
            status_reg    <= status_next;
            matched_reg   <= matched_next;
            sport_out_reg <= sport_out_next;
            dport_out_reg <= dport_out_next;
            sip_out_reg   <= sip_out_next;
            plen_reg      <= plen_next;
        end
    end

    assign result_valid     = out_valid_reg;
    assign status           = status_reg;
    assign matched_handler  = matched_reg;
    assign source_port      = sport_out_reg;
    assign destination_port = dport_out_reg;
    assign sender_ip        = sip_out_reg;
    assign payload_length   = plen_reg;

endmodule
`default_nettype wire
